/* rtl/hrs_pkg.sv */
package hrs_pkg;

    // Hue wheel geometry: six half segments of 255 steps each.
    localparam int unsigned HUE_STEPS = 1530;
    localparam int unsigned HUE_LAST  = 1529;
    localparam int unsigned SEG_LEN   = 510;
    localparam int unsigned HALF_SEG  = 255;

    // Reciprocals for exact division by a constant: floor(x * R >> S).
    // 1529: x < 2**22, shift 33.  255: x < 2**16, shift 24.
    localparam logic [22:0] RECIP_1529 = 23'd5618009;
    localparam int unsigned RECIP_1529_SHIFT = 33;
    localparam logic [16:0] RECIP_255 = 17'd65794;
    localparam int unsigned RECIP_255_SHIFT = 24;

    // Normalising divider: eight quotient bits, two per stage.
    localparam int unsigned DIV_STAGES = 4;

    localparam logic [1:0] CFG_RED_END  = 2'd0;
    localparam logic [1:0] CFG_BLUE_END = 2'd1;
    localparam logic [1:0] CFG_OFFSET   = 2'd2;

    typedef enum logic [1:0] {
        SEG_RED_GREEN,
        SEG_GREEN_BLUE,
        SEG_BLUE_RED
    } seg_t;

    // Pixel data that rides alongside the divider.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] grey;
        logic [7:0] chroma;
        logic [7:0] rd;
        logic [7:0] gd;
        logic [7:0] bd;
    } pix_t;

    typedef struct packed {
        logic [15:0] rem;
        logic [7:0]  quo;
    } div_t;

endpackage

/* rtl/hrs_div.sv */
module hrs_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       in_num,
    input  logic [7:0]        in_den,
    input  hrs_pkg::pix_t     in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_quo,
    output hrs_pkg::pix_t     out_side
);

    localparam int unsigned NST = hrs_pkg::DIV_STAGES;

    logic              vld_reg  [NST];
    hrs_pkg::div_t     div_reg  [NST];
    logic [7:0]        den_reg  [NST];
    hrs_pkg::pix_t     side_reg [NST];

    logic              adv      [NST];
    logic              vld_in   [NST];
    hrs_pkg::div_t     div_in   [NST];
    logic [7:0]        den_in   [NST];
    hrs_pkg::pix_t     side_in  [NST];
    hrs_pkg::div_t     div_next [NST];

    // One restoring step: try to take den << sh off the partial remainder.
    function automatic hrs_pkg::div_t div_bit(input hrs_pkg::div_t x,
                                              input logic [7:0] den,
                                              input logic [2:0] sh);
        hrs_pkg::div_t r;
        logic [15:0]   trial;
        r     = x;
        trial = {8'd0, den} << sh;
        if (x.rem >= trial) begin
            r.rem     = x.rem - trial;
            r.quo[sh] = 1'b1;
        end
        return r;
    endfunction

    for (genvar j = 0; j < NST; j++) begin : g_stage
        if (j == 0) begin : g_first
            assign vld_in[j]  = in_valid;
            assign div_in[j]  = '{rem: in_num, quo: 8'd0};
            assign den_in[j]  = in_den;
            assign side_in[j] = in_side;
        end else begin : g_rest
            assign vld_in[j]  = vld_reg[j-1];
            assign div_in[j]  = div_reg[j-1];
            assign den_in[j]  = den_reg[j-1];
            assign side_in[j] = side_reg[j-1];
        end
        if (j == NST - 1) begin : g_last
            assign adv[j] = !vld_reg[j] || out_ready;
        end else begin : g_mid
            assign adv[j] = !vld_reg[j] || adv[j+1];
        end
        assign div_next[j] = div_bit(div_bit(div_in[j], den_in[j], 3'(7 - 2 * j)),
                                     den_in[j], 3'(6 - 2 * j));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (adv[j]) begin
                vld_reg[j] <= vld_in[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j]) begin
                div_reg[j]  <= div_next[j];
                den_reg[j]  <= den_in[j];
                side_reg[j] <= side_in[j];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NST-1];
    assign out_quo   = div_reg[NST-1].quo;
    assign out_side  = side_reg[NST-1];

endmodule

/* rtl/hue_range_squeeze_core.sv */
// Hue range squeeze: remaps the hue of one RGBA pixel per item.
//
// Input channel s_*: alpha, red, green and blue bytes under s_valid/s_ready.
// Result channel m_*: the remapped pixel under m_valid/m_ready; alpha is
// carried through untouched. Every input item gives exactly one result.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 red end hue, 1 blue end hue, 2 hue offset) with no wait state. The
// registers should only be written while no item is in flight.
//
// Throughput is one item per clock while m_ready stays high. There are fifteen
// register stages from acceptance to m_valid: two front stages, the
// four-stage normalising divider and nine stages of hue and colour work.
//
// Reset clears all valid bits and loads the registers with red end 0, blue
// end 1529 and offset 0. When the receiver holds m_ready low the result
// stays in the output register; each stage holds only while the stage after
// it is full, so empty slots keep filling and s_ready stays high until the
// pipeline is full.
module hue_range_squeeze_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_alpha_in,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_alpha_out,
    output logic [7:0]  m_red_out,
    output logic [7:0]  m_green_out,
    output logic [7:0]  m_blue_out
);

    localparam int unsigned NBK = 9;

    // Payload of the back stages; each stage fills in the fields it owns.
    typedef struct packed {
        logic [7:0]  alpha;
        logic [7:0]  grey;
        logic [7:0]  chroma;
        logic [10:0] hue;
        logic [44:0] prod;
        logic [7:0]  pr;
        logic [7:0]  pg;
        logic [7:0]  pb;
        logic [15:0] cr;
        logic [15:0] cg;
        logic [15:0] cb;
        logic [32:0] sr;
        logic [32:0] sg;
        logic [32:0] sb;
    } bk_t;

    // ------------------------------------------------------------------
    // Configuration registers and the values derived from them.
    // ------------------------------------------------------------------
    logic [10:0] red_end_reg, blue_end_reg, offset_reg;
    logic [10:0] lo_next, hi_next;
    logic [10:0] off_next, off_reg;
    logic [10:0] span_next, span_reg;
    logic [10:0] base_next, base_reg;
    logic        rev_next, rev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_end_reg  <= 11'd0;
            blue_end_reg <= 11'(hrs_pkg::HUE_LAST);
            offset_reg   <= 11'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hrs_pkg::CFG_RED_END:  red_end_reg  <= cfg_wdata;
                hrs_pkg::CFG_BLUE_END: blue_end_reg <= cfg_wdata;
                hrs_pkg::CFG_OFFSET:   offset_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // End hues above the last step are clamped; the offset is reduced once,
    // which suffices since an 11-bit value is below twice the wheel size.
    always_comb begin
        lo_next  = (red_end_reg  > 11'(hrs_pkg::HUE_LAST)) ? 11'(hrs_pkg::HUE_LAST)
                                                          : red_end_reg;
        hi_next  = (blue_end_reg > 11'(hrs_pkg::HUE_LAST)) ? 11'(hrs_pkg::HUE_LAST)
                                                          : blue_end_reg;
        rev_next = !(hi_next > lo_next);
        span_next = rev_next ? (lo_next - hi_next) : (hi_next - lo_next);
        base_next = rev_next ? hi_next : lo_next;
        off_next  = (offset_reg >= 11'(hrs_pkg::HUE_STEPS))
                  ? (offset_reg - 11'(hrs_pkg::HUE_STEPS)) : offset_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg  <= 11'd0;
            span_reg <= 11'(hrs_pkg::HUE_LAST);
            base_reg <= 11'd0;
            rev_reg  <= 1'b0;
        end else begin
            off_reg  <= off_next;
            span_reg <= span_next;
            base_reg <= base_next;
            rev_reg  <= rev_next;
        end
    end

    // ------------------------------------------------------------------
    // Front stages: grey and channel differences, then chroma and the
    // dividend for the middle channel. The smallest difference is zero,
    // so only one channel ever needs a true division.
    // ------------------------------------------------------------------
    logic          f0_vld_reg, f1_vld_reg;
    logic          f0_adv, f1_adv;
    hrs_pkg::pix_t f0_reg, f0_next;
    hrs_pkg::pix_t f1_reg, f1_next;
    logic [15:0]   f1_num_reg, f1_num_next;
    logic [7:0]    grey_c;
    logic [9:0]    mid_sum;
    logic [7:0]    mid_c;
    logic          div_in_ready;

    always_comb begin
        grey_c = s_red_in;
        if (s_green_in < grey_c) begin
            grey_c = s_green_in;
        end
        if (s_blue_in < grey_c) begin
            grey_c = s_blue_in;
        end
        f0_next        = '0;
        f0_next.alpha  = s_alpha_in;
        f0_next.grey   = grey_c;
        f0_next.rd     = s_red_in   - grey_c;
        f0_next.gd     = s_green_in - grey_c;
        f0_next.bd     = s_blue_in  - grey_c;
    end

    always_comb begin
        f1_next        = f0_reg;
        f1_next.chroma = f0_reg.rd;
        if (f0_reg.gd > f1_next.chroma) begin
            f1_next.chroma = f0_reg.gd;
        end
        if (f0_reg.bd > f1_next.chroma) begin
            f1_next.chroma = f0_reg.bd;
        end
        mid_sum     = {2'd0, f0_reg.rd} + {2'd0, f0_reg.gd} + {2'd0, f0_reg.bd}
                    - {2'd0, f1_next.chroma};
        mid_c       = mid_sum[7:0];
        f1_num_next = {mid_c, 8'd0} - {8'd0, mid_c};
    end

    assign f1_adv  = !f1_vld_reg || div_in_ready;
    assign f0_adv  = !f0_vld_reg || f1_adv;
    assign s_ready = f0_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
        end else begin
            if (f0_adv) begin
                f0_vld_reg <= s_valid;
            end
            if (f1_adv) begin
                f1_vld_reg <= f0_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (f0_adv) begin
            f0_reg <= f0_next;
        end
        if (f1_adv) begin
            f1_reg     <= f1_next;
            f1_num_reg <= f1_num_next;
        end
    end

    // ------------------------------------------------------------------
    // Normalising divider: 255 * middle / chroma.
    // ------------------------------------------------------------------
    logic          div_out_valid;
    logic          div_out_ready;
    logic [7:0]    div_quo;
    hrs_pkg::pix_t div_side;

    hrs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f1_vld_reg),
        .in_ready  (div_in_ready),
        .in_num    (f1_num_reg),
        .in_den    (f1_reg.chroma),
        .in_side   (f1_reg),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Back stages:
    //   0 normalise and find the hue index   1 rotate by the offset
    //   2 squeeze product                    3 divide by 1529 (reciprocal)
    //   4 add the base end                   5 pure colour
    //   6 chroma products                    7 divide by 255 (reciprocal)
    //   8 add grey back (output register)
    // ------------------------------------------------------------------
    logic bk_vld_reg [NBK];
    bk_t  bk_reg     [NBK];
    bk_t  bk_next    [NBK];
    logic bk_adv     [NBK];
    logic bk_vld_in  [NBK];

    function automatic logic [7:0] norm(input logic [7:0] x,
                                        input logic [7:0] chroma,
                                        input logic [7:0] quo);
        logic [7:0] n;
        if (x == 8'd0) begin
            n = 8'd0;
        end else if (x == chroma) begin
            n = 8'd255;
        end else begin
            n = quo;
        end
        return n;
    endfunction

    logic [7:0]    rn, gn, bn;
    logic [10:0]   hue_c;
    logic [11:0]   rot_c;
    logic [10:0]   t_c;
    logic [11:0]   sq_c;
    logic [10:0]   pos_c;
    logic [8:0]    down_c;
    logic          rising_c;
    logic [7:0]    up_c, ramp_dn, ramp_up;
    hrs_pkg::seg_t seg_c;

    always_comb begin
        // Stage 0: normalised channels and the 1530-step hue index.
        bk_next[0]        = '0;
        bk_next[0].alpha  = div_side.alpha;
        bk_next[0].grey   = div_side.grey;
        bk_next[0].chroma = div_side.chroma;
        rn = norm(div_side.rd, div_side.chroma, div_quo);
        gn = norm(div_side.gd, div_side.chroma, div_quo);
        bn = norm(div_side.bd, div_side.chroma, div_quo);
        if (bn == 8'd0) begin
            hue_c = (rn >= gn) ? {3'd0, gn}
                               : (11'(hrs_pkg::SEG_LEN) - {3'd0, rn});
        end else if (gn == 8'd0) begin
            hue_c = (bn >= rn) ? (11'(2 * hrs_pkg::SEG_LEN) + {3'd0, rn})
                               : (11'(hrs_pkg::HUE_STEPS) - {3'd0, bn});
        end else begin
            hue_c = (gn >= bn) ? (11'(hrs_pkg::SEG_LEN) + {3'd0, bn})
                               : (11'(2 * hrs_pkg::SEG_LEN) - {3'd0, gn});
        end
        bk_next[0].hue = hue_c;

        // Stage 1: rotation with wrap at the wheel size.
        bk_next[1] = bk_reg[0];
        rot_c = {1'b0, bk_reg[0].hue} + {1'b0, off_reg};
        if (rot_c >= 12'(hrs_pkg::HUE_STEPS)) begin
            rot_c = rot_c - 12'(hrs_pkg::HUE_STEPS);
        end
        bk_next[1].hue = rot_c[10:0];

        // Stage 2: swapped ends run the hue backwards.
        bk_next[2] = bk_reg[1];
        t_c = rev_reg ? (11'(hrs_pkg::HUE_LAST) - bk_reg[1].hue) : bk_reg[1].hue;
        bk_next[2].prod = {23'd0, {11'd0, t_c} * {11'd0, span_reg}};

        // Stage 3: multiply by the reciprocal of 1529.
        bk_next[3] = bk_reg[2];
        bk_next[3].prod = {23'd0, bk_reg[2].prod[21:0]} * {22'd0, hrs_pkg::RECIP_1529};

        // Stage 4: quotient plus the lower end, clamped to the last step.
        bk_next[4] = bk_reg[3];
        sq_c = bk_reg[3].prod[44:hrs_pkg::RECIP_1529_SHIFT] + {1'b0, base_reg};
        if (sq_c > 12'(hrs_pkg::HUE_LAST)) begin
            sq_c = 12'(hrs_pkg::HUE_LAST);
        end
        bk_next[4].hue = sq_c[10:0];

        // Stage 5: piecewise pure colour for the new index.
        bk_next[5] = bk_reg[4];
        if (bk_reg[4].hue >= 11'(2 * hrs_pkg::SEG_LEN)) begin
            seg_c = hrs_pkg::SEG_BLUE_RED;
            pos_c = bk_reg[4].hue - 11'(2 * hrs_pkg::SEG_LEN);
        end else if (bk_reg[4].hue >= 11'(hrs_pkg::SEG_LEN)) begin
            seg_c = hrs_pkg::SEG_GREEN_BLUE;
            pos_c = bk_reg[4].hue - 11'(hrs_pkg::SEG_LEN);
        end else begin
            seg_c = hrs_pkg::SEG_RED_GREEN;
            pos_c = bk_reg[4].hue;
        end
        rising_c = pos_c < 11'(hrs_pkg::HALF_SEG);
        up_c     = pos_c[7:0];
        down_c   = 9'(hrs_pkg::SEG_LEN) - pos_c[8:0];
        ramp_dn  = rising_c ? 8'd255 : down_c[7:0];
        ramp_up  = rising_c ? up_c : 8'd255;
        case (seg_c)
            hrs_pkg::SEG_RED_GREEN: begin
                bk_next[5].pr = ramp_dn;
                bk_next[5].pg = ramp_up;
                bk_next[5].pb = 8'd0;
            end
            hrs_pkg::SEG_GREEN_BLUE: begin
                bk_next[5].pr = 8'd0;
                bk_next[5].pg = ramp_dn;
                bk_next[5].pb = ramp_up;
            end
            hrs_pkg::SEG_BLUE_RED: begin
                bk_next[5].pr = ramp_up;
                bk_next[5].pg = 8'd0;
                bk_next[5].pb = ramp_dn;
            end
            default: begin
                bk_next[5].pr = 8'd0;
                bk_next[5].pg = 8'd0;
                bk_next[5].pb = 8'd0;
            end
        endcase

        // Stage 6: scale the pure colour by chroma.
        bk_next[6] = bk_reg[5];
        bk_next[6].cr = {8'd0, bk_reg[5].chroma} * {8'd0, bk_reg[5].pr};
        bk_next[6].cg = {8'd0, bk_reg[5].chroma} * {8'd0, bk_reg[5].pg};
        bk_next[6].cb = {8'd0, bk_reg[5].chroma} * {8'd0, bk_reg[5].pb};

        // Stage 7: multiply by the reciprocal of 255.
        bk_next[7] = bk_reg[6];
        bk_next[7].sr = {17'd0, bk_reg[6].cr} * {16'd0, hrs_pkg::RECIP_255};
        bk_next[7].sg = {17'd0, bk_reg[6].cg} * {16'd0, hrs_pkg::RECIP_255};
        bk_next[7].sb = {17'd0, bk_reg[6].cb} * {16'd0, hrs_pkg::RECIP_255};

        // Stage 8: take the quotients and add grey back.
        bk_next[8] = bk_reg[7];
        bk_next[8].pr = bk_reg[7].sr[hrs_pkg::RECIP_255_SHIFT +: 8] + bk_reg[7].grey;
        bk_next[8].pg = bk_reg[7].sg[hrs_pkg::RECIP_255_SHIFT +: 8] + bk_reg[7].grey;
        bk_next[8].pb = bk_reg[7].sb[hrs_pkg::RECIP_255_SHIFT +: 8] + bk_reg[7].grey;
    end

    for (genvar i = 0; i < NBK; i++) begin : g_bk
        if (i == 0) begin : g_first
            assign bk_vld_in[i] = div_out_valid;
        end else begin : g_rest
            assign bk_vld_in[i] = bk_vld_reg[i-1];
        end
        if (i == NBK - 1) begin : g_last
            assign bk_adv[i] = !bk_vld_reg[i] || m_ready;
        end else begin : g_mid
            assign bk_adv[i] = !bk_vld_reg[i] || bk_adv[i+1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                bk_vld_reg[i] <= 1'b0;
            end else if (bk_adv[i]) begin
                bk_vld_reg[i] <= bk_vld_in[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (bk_adv[i]) begin
                bk_reg[i] <= bk_next[i];
            end
        end
    end

    assign div_out_ready = bk_adv[0];

    assign m_valid     = bk_vld_reg[NBK-1];
    assign m_alpha_out = bk_reg[NBK-1].alpha;
    assign m_red_out   = bk_reg[NBK-1].pr;
    assign m_green_out = bk_reg[NBK-1].pg;
    assign m_blue_out  = bk_reg[NBK-1].pb;

`ifndef SYNTH
    // A stalled output register must keep the item behind it in place.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (bk_vld_reg[NBK-1] && !m_ready && bk_vld_reg[NBK-2]) |=> bk_vld_reg[NBK-2])
        else $error("item behind a stalled output was lost");

    // The input side only refuses an item when the first stage is occupied.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> f0_vld_reg)
        else $error("s_ready low with an empty first stage");

    // The squeezed hue never leaves the wheel.
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_vld_reg[4] |-> (bk_reg[4].hue <= 11'(hrs_pkg::HUE_LAST)))
        else $error("squeezed hue out of range");

    // Every pure colour has one channel at full scale.
    a_pure_full: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_vld_reg[5] |-> (bk_reg[5].pr == 8'd255 || bk_reg[5].pg == 8'd255
                           || bk_reg[5].pb == 8'd255))
        else $error("pure colour without a full channel");
`endif

endmodule

/* tb/testbench.sv */
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Fifteen register stages between acceptance and m_valid.
    localparam int unsigned PIPE_LATENCY    = 15;
    // The receiver's deliberate hold-off, long enough to fill the pipeline.
    localparam int unsigned LONG_HOLD       = 60;
    // Cycles without a single accepted item before the run is abandoned.
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned FIXED_SETTINGS  = 10;
    localparam int unsigned RANDOM_SETTINGS = 2;
    localparam int unsigned ITEMS_PER_PHASE = 42;
    localparam int unsigned DIRECTED_ROWS   = 20;
    // Register index that the block does not decode; a write there must change nothing.
    localparam logic [1:0]  CFG_SPARE       = 2'd3;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgba_t;

    // One row of the directed table. Where known is set, want holds the result as
    // it can be read straight off the hue wheel under the reset register values.
    typedef struct packed {
        rgba_t px;
        logic  known;
        rgba_t want;
    } directed_row_t;

    typedef struct packed {
        logic [10:0] red_end;
        logic [10:0] blue_end;
        logic [10:0] offset;
    } hue_setting_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_alpha_in;
    logic [7:0]  s_red_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_blue_in;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_alpha_out;
    logic [7:0]  m_red_out;
    logic [7:0]  m_green_out;
    logic [7:0]  m_blue_out;

    hue_range_squeeze_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_alpha_in  (s_alpha_in),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_alpha_out (m_alpha_out),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

    // Our own copy of the three hue registers, updated as each write is issued.
    logic [10:0] red_end_reg;
    logic [10:0] blue_end_reg;
    logic [10:0] offset_reg;

    // Remapped pixels still owed by the block, oldest first.
    rgba_t       owed_pixels[$];

    int unsigned error_count;
    int unsigned pixels_sent;
    int unsigned pixels_checked;
    int unsigned settings_used;
    int unsigned input_stall_cycles;
    int unsigned quiet_cycles;

    // Shared between the sender and the receiver pacing process.
    bit          phase_steady;
    bit          backlog_req;

    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // Black, white and mid grey come back untouched.
        '{'{8'h00, 8'd0,   8'd0,   8'd0  }, 1'b1, '{8'h00, 8'd0,   8'd0,   8'd0  }},
        '{'{8'hFF, 8'd255, 8'd255, 8'd255}, 1'b1, '{8'hFF, 8'd255, 8'd255, 8'd255}},
        '{'{8'h5A, 8'd128, 8'd128, 8'd128}, 1'b1, '{8'h5A, 8'd128, 8'd128, 8'd128}},
        // The six corners of the hue wheel map to themselves with the reset span.
        '{'{8'hFF, 8'd255, 8'd0,   8'd0  }, 1'b1, '{8'hFF, 8'd255, 8'd0,   8'd0  }},
        '{'{8'h00, 8'd0,   8'd255, 8'd0  }, 1'b1, '{8'h00, 8'd0,   8'd255, 8'd0  }},
        '{'{8'h80, 8'd0,   8'd0,   8'd255}, 1'b1, '{8'h80, 8'd0,   8'd0,   8'd255}},
        '{'{8'h7F, 8'd255, 8'd255, 8'd0  }, 1'b1, '{8'h7F, 8'd255, 8'd255, 8'd0  }},
        '{'{8'h01, 8'd0,   8'd255, 8'd255}, 1'b1, '{8'h01, 8'd0,   8'd255, 8'd255}},
        '{'{8'hFE, 8'd255, 8'd0,   8'd255}, 1'b1, '{8'hFE, 8'd255, 8'd0,   8'd255}},
        // Smallest possible chroma, and a grey one step below white.
        '{'{8'h55, 8'd1,   8'd0,   8'd0  }, 1'b1, '{8'h55, 8'd1,   8'd0,   8'd0  }},
        '{'{8'hAA, 8'd254, 8'd254, 8'd254}, 1'b1, '{8'hAA, 8'd254, 8'd254, 8'd254}},
        // Mid points of each segment and odd mixes, left to the predictor.
        '{'{8'h33, 8'd255, 8'd128, 8'd0  }, 1'b0, '0},
        '{'{8'hCC, 8'd128, 8'd255, 8'd0  }, 1'b0, '0},
        '{'{8'h0F, 8'd0,   8'd255, 8'd128}, 1'b0, '0},
        '{'{8'hF0, 8'd0,   8'd128, 8'd255}, 1'b0, '0},
        '{'{8'h3C, 8'd128, 8'd0,   8'd255}, 1'b0, '0},
        '{'{8'hC3, 8'd255, 8'd0,   8'd1  }, 1'b0, '0},
        '{'{8'h96, 8'd200, 8'd100, 8'd50 }, 1'b0, '0},
        '{'{8'h69, 8'd10,  8'd20,  8'd30 }, 1'b0, '0},
        '{'{8'h18, 8'd254, 8'd1,   8'd127}, 1'b0, '0}
    };

    // Fixed register settings: the reset span, a fully reversed span, a half-turn
    // rotation, equal ends, and values above 1529 that must be clamped or wrapped.
    hue_setting_t fixed_settings [0:FIXED_SETTINGS-1] = '{
        '{11'd0,    11'd1529, 11'd0   },
        '{11'd1529, 11'd0,    11'd0   },
        '{11'd0,    11'd1529, 11'd765 },
        '{11'd700,  11'd700,  11'd100 },
        '{11'd2047, 11'd0,    11'd1530},
        '{11'd0,    11'd2047, 11'd2047},
        '{11'd2047, 11'd2047, 11'd1529},
        '{11'd300,  11'd1200, 11'd200 },
        '{11'd1400, 11'd100,  11'd1000},
        '{11'd0,    11'd0,    11'd0   }
    };

    // Half a period of 10 ns gives the 20 ns clock.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // The predictor. The pixel is split into grey and chroma, the grey-free
    // channels are stretched so that the largest reaches 255, and the hue index
    // is read from whichever channel is zero. After rotation and squeezing into
    // the configured span, the pure colour at the new index is scaled back by
    // chroma and the grey is added in again.
    function automatic rgba_t remap_pixel(input rgba_t px);
        int unsigned r, g, b, grey, chroma, hue, lo, hi, pos, pr, pg, pb, up, down;
        bit          rising;
        rgba_t       res;
        r = px.red;
        g = px.green;
        b = px.blue;
        grey = r;
        if (g < grey) grey = g;
        if (b < grey) grey = b;
        r -= grey;
        g -= grey;
        b -= grey;
        chroma = r;
        if (g > chroma) chroma = g;
        if (b > chroma) chroma = b;
        if (chroma != 0) begin
            r = (255 * r) / chroma;
            g = (255 * g) / chroma;
            b = (255 * b) / chroma;
        end

        if (b == 0) begin
            hue = (r >= g) ? g : hrs_pkg::SEG_LEN - r;
        end else if (g == 0) begin
            hue = (b >= r) ? 2 * hrs_pkg::SEG_LEN + r : hrs_pkg::HUE_STEPS - b;
        end else begin
            hue = (g >= b) ? hrs_pkg::SEG_LEN + b : 2 * hrs_pkg::SEG_LEN - g;
        end

        hue = (hue + offset_reg % hrs_pkg::HUE_STEPS) % hrs_pkg::HUE_STEPS;

        // End registers above the last hue behave as the last hue.
        lo = (red_end_reg > hrs_pkg::HUE_LAST) ? hrs_pkg::HUE_LAST : red_end_reg;
        hi = (blue_end_reg > hrs_pkg::HUE_LAST) ? hrs_pkg::HUE_LAST : blue_end_reg;
        if (hi > lo) begin
            hue = (hue * (hi - lo)) / hrs_pkg::HUE_LAST + lo;
        end else begin
            // A reversed or empty span walks the wheel backwards from the blue end.
            hue = ((hrs_pkg::HUE_LAST - hue) * (lo - hi)) / hrs_pkg::HUE_LAST + hi;
        end
        if (hue > hrs_pkg::HUE_LAST) hue = hrs_pkg::HUE_LAST;

        pos = hue % hrs_pkg::SEG_LEN;
        up = pos;
        rising = (pos < hrs_pkg::HALF_SEG);
        down = rising ? 0 : hrs_pkg::HALF_SEG - (pos - hrs_pkg::HALF_SEG);
        case (hrs_pkg::seg_t'(hue / hrs_pkg::SEG_LEN))
            hrs_pkg::SEG_RED_GREEN: begin
                pr = rising ? 255 : down;
                pg = rising ? up : 255;
                pb = 0;
            end
            hrs_pkg::SEG_GREEN_BLUE: begin
                pr = 0;
                pg = rising ? 255 : down;
                pb = rising ? up : 255;
            end
            default: begin
                pr = rising ? up : 255;
                pg = 0;
                pb = rising ? 255 : down;
            end
        endcase

        res.alpha = px.alpha;
        res.red   = 8'((chroma * pr) / 255 + grey);
        res.green = 8'((chroma * pg) / 255 + grey);
        res.blue  = 8'((chroma * pb) / 255 + grey);
        return res;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Random pixels with a bias towards the awkward ones: greys, fully saturated
    // colours, channels at 0 or 255, tiny chroma and pairs of equal channels.
    function automatic rgba_t random_pixel();
        rgba_t       px;
        logic [7:0]  lvl;
        logic [7:0]  ch [0:2];
        int unsigned first, second, base;
        px = rgba_t'($urandom);
        lvl = 8'($urandom);
        case ($urandom_range(0, 9))
            5: begin
                px.red = lvl;
                px.green = lvl;
                px.blue = lvl;
            end
            6: begin
                first = $urandom_range(0, 2);
                second = (first + 1 + $urandom_range(0, 1)) % 3;
                ch[first] = 8'd255;
                ch[second] = 8'd0;
                ch[3 - first - second] = lvl;
                px.red = ch[0];
                px.green = ch[1];
                px.blue = ch[2];
            end
            7: begin
                px.red = {8{1'($urandom_range(0, 1))}};
                px.green = {8{1'($urandom_range(0, 1))}};
                px.blue = {8{1'($urandom_range(0, 1))}};
            end
            8: begin
                base = $urandom_range(0, 250);
                px.red = 8'(base + $urandom_range(0, 5));
                px.green = 8'(base + $urandom_range(0, 5));
                px.blue = 8'(base + $urandom_range(0, 5));
            end
            9: begin
                case ($urandom_range(0, 2))
                    0: px.green = px.red;
                    1: px.blue = px.green;
                    default: px.red = px.blue;
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    // One register write, applied at the next rising edge.
    task automatic write_hue_reg(input logic [1:0] index, input logic [10:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            hrs_pkg::CFG_RED_END:  red_end_reg = value;
            hrs_pkg::CFG_BLUE_END: blue_end_reg = value;
            hrs_pkg::CFG_OFFSET:   offset_reg = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offers one pixel and holds it until the block takes it. The expected result
    // is queued at the edge of acceptance. When a gap precedes the pixel, valid is
    // lowered at one falling edge and raised at a later one, never both at once.
    task automatic offer_pixel(input rgba_t px, input bit known, input rgba_t want);
        int unsigned gap;
        gap = phase_steady ? 0 : idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_alpha_in <= px.alpha;
        s_red_in   <= px.red;
        s_green_in <= px.green;
        s_blue_in  <= px.blue;
        do @(posedge aclk); while (!s_ready);
        owed_pixels.push_back(known ? want : remap_pixel(px));
        pixels_sent++;
    endtask

    // Stops offering and waits until every owed pixel has come back.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
            error_count++;
        end
    endtask

    // Result checker: every accepted pixel is matched against the oldest one owed.
    always @(posedge aclk) begin
        rgba_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %0d %0d %0d %0d with nothing owed",
                         $realtime, m_alpha_out, m_red_out, m_green_out, m_blue_out);
                error_count++;
            end else begin
                want = owed_pixels.pop_front();
                report_field("alpha", want.alpha, m_alpha_out);
                report_field("red", want.red, m_red_out);
                report_field("green", want.green, m_green_out);
                report_field("blue", want.blue, m_blue_out);
                pixels_checked++;
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves an item. It also tallies
    // how long the input was held off, for the closing summary.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (s_valid && !s_ready) input_stall_cycles <= input_stall_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver pacing. Usually ready, sometimes stalled for a random stretch, and
    // once held off for a long stretch on request so that the pipeline fills and
    // the input side has to stall.
    initial begin : sink_pacing
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (backlog_req) begin
                backlog_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (phase_steady || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                stall = 1 + idle_len();
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        hue_setting_t setting;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = hrs_pkg::CFG_RED_END;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_alpha_in = '0;
        s_red_in = '0;
        s_green_in = '0;
        s_blue_in = '0;
        red_end_reg = 11'd0;
        blue_end_reg = 11'd1529;
        offset_reg = 11'd0;
        error_count = 0;
        pixels_sent = 0;
        pixels_checked = 0;
        settings_used = 1;
        input_stall_cycles = 0;
        quiet_cycles = 0;
        phase_steady = 1'b0;
        backlog_req = 1'b0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table under the reset register values.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].want);
        end
        drain_pipeline();

        // Random pixels across a series of register settings. The block is empty
        // whenever the registers change, as every pixel gives exactly one result.
        for (int phase = 0; phase < FIXED_SETTINGS + RANDOM_SETTINGS; phase++) begin
            if (phase < FIXED_SETTINGS) begin
                setting = fixed_settings[phase];
            end else begin
                setting.red_end = 11'($urandom_range(0, 2047));
                setting.blue_end = 11'($urandom_range(0, 2047));
                setting.offset = 11'($urandom_range(0, 2047));
            end
            write_hue_reg(hrs_pkg::CFG_RED_END, setting.red_end);
            write_hue_reg(hrs_pkg::CFG_BLUE_END, setting.blue_end);
            write_hue_reg(hrs_pkg::CFG_OFFSET, setting.offset);
            // An undecoded index with every data bit set must leave the registers alone.
            if (phase == 4) write_hue_reg(CFG_SPARE, 11'h7FF);
            settings_used++;

            // Two phases run without gaps on either side; in the second of them the
            // receiver also holds off for a long stretch.
            phase_steady = (phase == 2 || phase == 3);
            if (phase == 3) backlog_req = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer_pixel(random_pixel(), 1'b0, '0);
            end
            drain_pipeline();
        end
        phase_steady = 1'b0;

        // Let any stray result surface before the verdict.
        repeat (PIPE_LATENCY + 5) @(posedge aclk);
        if (owed_pixels.size() != 0) begin
            $display("%0t: %0d pixels never came back", $realtime, owed_pixels.size());
            error_count++;
        end

        $display("Remapped %0d pixels (%0d checked) under %0d hue span and offset settings.",
                 pixels_sent, pixels_checked, settings_used);
        $display("Input side was held off for %0d cycles by output back-pressure.",
                 input_stall_cycles);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
